@@ rtl/bhz_pkg.sv @@
// shared types, register map and event codes of the button hold zone classifier
package bhz_pkg;

   localparam int DEBOUNCE_W = 8;
   localparam int HOLD_W     = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_SETTLE_TICKS    = 3'd0;
   localparam logic [2:0] REG_HOLD_CONNECT_MS = 3'd1;
   localparam logic [2:0] REG_HOLD_PAIR_MS    = 3'd2;
   localparam logic [2:0] REG_HOLD_MODE_MS    = 3'd3;
   localparam logic [2:0] REG_EMIT_ENABLED    = 3'd4;

   localparam logic [DEBOUNCE_W-1:0] SETTLE_TICKS_RST    = 8'd20;
   localparam logic [HOLD_W-1:0]     HOLD_CONNECT_MS_RST = 16'd3000;
   localparam logic [HOLD_W-1:0]     HOLD_PAIR_MS_RST    = 16'd6000;
   localparam logic [HOLD_W-1:0]     HOLD_MODE_MS_RST    = 16'd9000;

   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_CANCEL = 1'b1;

   localparam logic [2:0] BEV_NONE         = 3'd0;
   localparam logic [2:0] BEV_SHORT        = 3'd1;
   localparam logic [2:0] BEV_CONNECT      = 3'd2;
   localparam logic [2:0] BEV_PAIR         = 3'd3;
   localparam logic [2:0] BEV_MODE         = 3'd4;
   localparam logic [2:0] BEV_ZONE_CONNECT = 3'd5;
   localparam logic [2:0] BEV_ZONE_PAIR    = 3'd6;
   localparam logic [2:0] BEV_ZONE_MODE    = 3'd7;

   localparam logic [1:0] JEV_NONE      = 2'd0;
   localparam logic [1:0] JEV_PLUGGED   = 2'd1;
   localparam logic [1:0] JEV_UNPLUGGED = 2'd2;

   localparam logic [1:0] STAGE_IDLE    = 2'd0;
   localparam logic [1:0] STAGE_CONNECT = 2'd1;
   localparam logic [1:0] STAGE_PAIR    = 2'd2;
   localparam logic [1:0] STAGE_MODE    = 2'd3;

   typedef struct packed {
      logic mode;
      logic button_level;
      logic detect_level;
   } req_type;

   typedef struct packed {
      logic [2:0] button_event;
      logic [1:0] jack_event;
      logic [1:0] held_stage;
      logic       pressed_now;
      logic       plugged_now;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic load;
      logic clear_wait;
   } dbc_ctrl_type;

   typedef struct packed {
      logic accepted_next;
      logic changed;
   } dbc_stat_type;

endpackage

@@ rtl/bhz_debounce.sv @@
// one debounce channel: wait counter and accepted level
module bhz_debounce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bhz_pkg::DEBOUNCE_W-1:0] settle_ticks,
   input  bhz_pkg::dbc_ctrl_type          ctrl,
   input  logic                           level,
   output bhz_pkg::dbc_stat_type          stat
);
   import bhz_pkg::*;

   logic [DEBOUNCE_W-1:0] wait_ff;
   logic [DEBOUNCE_W-1:0] wait_in;
   logic                  acc_ff;
   logic                  acc_in;
   logic                  changed;

   always_comb begin
      wait_in = wait_ff;
      acc_in  = acc_ff;
      changed = 1'b0;
      if (ctrl.load) begin
         acc_in = level;
         if (ctrl.clear_wait) begin
            wait_in = '0;
         end
      end else if (ctrl.step) begin
         if (wait_ff != '0) begin
            wait_in = wait_ff - 1'b1;
            if (wait_ff == DEBOUNCE_W'(1) && level != acc_ff) begin
               acc_in  = level;
               changed = 1'b1;
            end
         end else if (level != acc_ff) begin
            // zero acts as one tick
            wait_in = (settle_ticks == '0) ? DEBOUNCE_W'(1) : settle_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= '0;
         acc_ff  <= 1'b0;
      end else begin
         wait_ff <= wait_in;
         acc_ff  <= acc_in;
      end
   end

   assign stat.accepted_next = acc_in;
   assign stat.changed       = changed;

endmodule

@@ rtl/button_hold_zone_classifier.sv @@
// top level: debounced button and jack classifier with long-press hold zones
//
//  channel  | ports                       | width  | direction
//  req      | req_valid/req_ready/req_data | 3 bit  | in
//  rsp      | rsp_valid/rsp_ready/rsp_data | 9 bit  | out
//  csr      | csr_p* apb-style             | 32 bit | in/out
//
// one item per cycle unless stalled; each accepted item gives exactly one result next cycle
// the whole state update is one pass of compare and increment logic into the result register
// req_ready is high whenever the result register is empty or being drained
// a stalled result holds the block and no new item is taken until it moves
// reset is synchronous and needs no clearing pass
module button_hold_zone_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bhz_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bhz_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bhz_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bhz_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bhz_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bhz_pkg::*;

   logic [DEBOUNCE_W-1:0] settle_ticks_ff;
   logic [HOLD_W-1:0]     hold_connect_ms_ff;
   logic [HOLD_W-1:0]     hold_pair_ms_ff;
   logic [HOLD_W-1:0]     hold_mode_ms_ff;
   logic                  emit_enabled_ff;

   logic                  booted_ff;
   logic                  booted_in;
   logic [HOLD_W-1:0]     hold_count_ff;
   logic [HOLD_W-1:0]     hold_count_in;
   logic                  hold_running_ff;
   logic                  hold_running_in;
   logic [1:0]            stage_ff;
   logic [1:0]            stage_in;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   logic                  accept;
   logic                  csr_write;
   logic [2:0]            csr_index;
   logic                  btn_pressed;
   logic [2:0]            bev;
   logic [1:0]            jev;
   logic [HOLD_W-1:0]     count_inc;

   dbc_ctrl_type          btn_ctrl;
   dbc_ctrl_type          jack_ctrl;
   dbc_stat_type          btn_stat;
   dbc_stat_type          jack_stat;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_SETTLE_TICKS:    csr_prdata = CSR_DATA_W'(settle_ticks_ff);
         REG_HOLD_CONNECT_MS: csr_prdata = CSR_DATA_W'(hold_connect_ms_ff);
         REG_HOLD_PAIR_MS:    csr_prdata = CSR_DATA_W'(hold_pair_ms_ff);
         REG_HOLD_MODE_MS:    csr_prdata = CSR_DATA_W'(hold_mode_ms_ff);
         REG_EMIT_ENABLED:    csr_prdata = CSR_DATA_W'(emit_enabled_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff    <= SETTLE_TICKS_RST;
         hold_connect_ms_ff <= HOLD_CONNECT_MS_RST;
         hold_pair_ms_ff    <= HOLD_PAIR_MS_RST;
         hold_mode_ms_ff    <= HOLD_MODE_MS_RST;
         emit_enabled_ff    <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SETTLE_TICKS:    settle_ticks_ff    <= csr_pwdata[DEBOUNCE_W-1:0];
            REG_HOLD_CONNECT_MS: hold_connect_ms_ff <= csr_pwdata[HOLD_W-1:0];
            REG_HOLD_PAIR_MS:    hold_pair_ms_ff    <= csr_pwdata[HOLD_W-1:0];
            REG_HOLD_MODE_MS:    hold_mode_ms_ff    <= csr_pwdata[HOLD_W-1:0];
            REG_EMIT_ENABLED:    emit_enabled_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // debounce control
   assign btn_pressed = !req_data.button_level;

   always_comb begin
      btn_ctrl  = '0;
      jack_ctrl = '0;
      if (accept) begin
         if (req_data.mode == MODE_CANCEL) begin
            btn_ctrl.load = 1'b1;
         end else if (!booted_ff) begin
            btn_ctrl.load        = 1'b1;
            btn_ctrl.clear_wait  = 1'b1;
            jack_ctrl.load       = 1'b1;
            jack_ctrl.clear_wait = 1'b1;
         end else begin
            btn_ctrl.step  = 1'b1;
            jack_ctrl.step = 1'b1;
         end
      end
   end

   bhz_debounce u_btn_dbc (
      .clock        (clock),
      .reset        (reset),
      .settle_ticks (settle_ticks_ff),
      .ctrl         (btn_ctrl),
      .level        (btn_pressed),
      .stat         (btn_stat)
   );

   bhz_debounce u_jack_dbc (
      .clock        (clock),
      .reset        (reset),
      .settle_ticks (settle_ticks_ff),
      .ctrl         (jack_ctrl),
      .level        (req_data.detect_level),
      .stat         (jack_stat)
   );

   // hold counter and zone ladder
   assign count_inc = (hold_count_ff == '1) ? hold_count_ff : hold_count_ff + 1'b1;

   always_comb begin
      booted_in       = booted_ff;
      hold_count_in   = hold_count_ff;
      hold_running_in = hold_running_ff;
      stage_in        = stage_ff;
      bev             = BEV_NONE;
      jev             = JEV_NONE;
      if (req_data.mode == MODE_CANCEL) begin
         hold_running_in = 1'b0;
         stage_in        = STAGE_IDLE;
      end else if (!booted_ff) begin
         booted_in       = 1'b1;
         hold_count_in   = '0;
         hold_running_in = 1'b0;
         stage_in        = STAGE_IDLE;
      end else begin
         if (btn_stat.changed) begin
            if (btn_stat.accepted_next) begin
               hold_count_in   = '0;
               hold_running_in = 1'b1;
               stage_in        = STAGE_IDLE;
            end else begin
               hold_running_in = 1'b0;
               bev             = BEV_SHORT + {1'b0, stage_ff};
            end
         end else if (hold_running_ff && btn_stat.accepted_next) begin
            hold_count_in = count_inc;
            priority if (stage_ff == STAGE_IDLE && count_inc >= hold_connect_ms_ff) begin
               stage_in = STAGE_CONNECT;
               bev      = BEV_ZONE_CONNECT;
            end else if (stage_ff == STAGE_CONNECT && count_inc >= hold_pair_ms_ff) begin
               stage_in = STAGE_PAIR;
               bev      = BEV_ZONE_PAIR;
            end else if (stage_ff == STAGE_PAIR && count_inc >= hold_mode_ms_ff) begin
               stage_in = STAGE_MODE;
               bev      = BEV_ZONE_MODE;
            end else begin
               stage_in = stage_ff;
            end
         end
         if (jack_stat.changed) begin
            jev = jack_stat.accepted_next ? JEV_PLUGGED : JEV_UNPLUGGED;
         end
      end
   end

   always_comb begin
      rsp_data_in.button_event = emit_enabled_ff ? bev : BEV_NONE;
      rsp_data_in.jack_event   = emit_enabled_ff ? jev : JEV_NONE;
      rsp_data_in.held_stage   = stage_in;
      rsp_data_in.pressed_now  = btn_stat.accepted_next;
      rsp_data_in.plugged_now  = jack_stat.accepted_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         booted_ff       <= 1'b0;
         hold_count_ff   <= '0;
         hold_running_ff <= 1'b0;
         stage_ff        <= STAGE_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            booted_ff       <= booted_in;
            hold_count_ff   <= hold_count_in;
            hold_running_ff <= hold_running_in;
            stage_ff        <= stage_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
